/* hw/rtl/bba_pkg.sv */
// buddy block allocator: shared constants, types and helper functions
// used by the front, queue, back and top rtl files; no dependencies
package bba_pkg;

	localparam int MIN_BLOCKS = 1024;
	localparam int LEVELS     = 10;
	localparam int ROW_W      = 32;
	localparam int POS_W      = $clog2(ROW_W);
	localparam int IDX_W      = $clog2(MIN_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int ADDR_W     = 64;
	localparam int SIZE_W     = 32;
	localparam int LOG_W      = 6;
	localparam int POOL_W     = 11;
	localparam int CFG_IDX_W  = 2;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_INIT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POOL = 2'd3;

	function automatic int rows_of(input int lv);
		int r;
		r = (MIN_BLOCKS >> lv) / ROW_W;
		return (r == 0) ? 1 : r;
	endfunction

	function automatic int row_base(input int lv);
		int off;
		off = 0;
		for (int j = 0; j < LEVELS; j++) begin
			if (j < lv) off += rows_of(j);
		end
		return off;
	endfunction

	localparam int ROWS   = row_base(LEVELS);
	localparam int ROW_AW = $clog2(ROWS);
	localparam int RIL_W  = $clog2(rows_of(0) + 1);

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_TOO_LARGE = 2'd1,
		STS_NO_FREE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_ALLOC,
		CMD_FREE,
		CMD_INIT,
		CMD_NOP,
		CMD_BIG
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [LVL_W-1:0]  lv;
		logic [IDX_W-1:0]  idx;
		logic [LOG_W-1:0]  k;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base_address;
		logic [LOG_W-1:0]  min_block_log2;
		logic [LOG_W-1:0]  max_block_log2;
		logic [POOL_W-1:0] pool_min_blocks;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_SET,
		PH_CLR,
		PH_FINAL,
		PH_FREE
	} phase_t;

	function automatic logic [LVL_W-1:0] top_level(input cfg_t c);
		logic [LOG_W:0] n;
		n = {1'b0, c.max_block_log2} - {1'b0, c.min_block_log2} + (LOG_W+1)'(1);
		if (c.max_block_log2 < c.min_block_log2) return '0;
		if (n > (LOG_W+1)'(LEVELS)) n = (LOG_W+1)'(LEVELS);
		return LVL_W'(n - (LOG_W+1)'(1));
	endfunction

	function automatic logic [CNT_W-1:0] pool_clamp(input cfg_t c);
		if (32'(c.pool_min_blocks) > 32'(MIN_BLOCKS)) return CNT_W'(MIN_BLOCKS);
		return CNT_W'(c.pool_min_blocks);
	endfunction

	function automatic logic [ROW_AW-1:0] row_addr(input logic [LVL_W-1:0] lv,
			input logic [RIL_W-1:0] ril);
		return ROW_AW'(row_base(int'(lv)) + int'(ril));
	endfunction

	function automatic logic [LVL_W-1:0] level_of_row(input logic [ROW_AW-1:0] r);
		logic [LVL_W-1:0] l;
		l = '0;
		for (int j = 0; j < LEVELS; j++) begin
			if (int'(r) >= row_base(j)) l = LVL_W'(j);
		end
		return l;
	endfunction

	function automatic logic [ROW_W-1:0] inval_mask(input logic [CNT_W-1:0] pc,
			input logic [LVL_W-1:0] lv, input logic [RIL_W-1:0] ril);
		logic [ROW_W-1:0] m;
		int cnt;
		cnt = int'(pc >> lv);
		for (int j = 0; j < ROW_W; j++) begin
			m[j] = ((int'(ril) << POS_W) + j) >= cnt;
		end
		return m;
	endfunction

endpackage

/* hw/rtl/bba_if.sv */
// buddy block allocator: request and response channel interfaces
// no dependencies
interface bba_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] request_size;
	logic [63:0] free_address;
	modport source(output valid, operation, request_size, free_address, input ready);
	modport sink(input valid, operation, request_size, free_address, output ready);
endinterface

interface bba_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] block_address;
	modport source(output valid, status, block_address, input ready);
	modport sink(input valid, status, block_address, output ready);
endinterface

/* hw/rtl/bba_front.sv */
// buddy block allocator front: accepts requests and classifies them into commands
// depends on bba_pkg and bba_if
module bba_front (
	bba_req_if.sink          req,
	input  bba_pkg::cfg_t    cfg,
	input  logic             sweep_busy,
	input  logic             q_full,
	output logic             push,
	output bba_pkg::cmd_t    cmd
);

	logic [bba_pkg::SIZE_W-1:0] sm1;
	logic [bba_pkg::LOG_W-1:0]  hb;
	logic [bba_pkg::LOG_W-1:0]  k;
	logic [bba_pkg::LVL_W-1:0]  top;
	logic                       big;
	logic [bba_pkg::LVL_W-1:0]  lv;
	logic [bba_pkg::ADDR_W-1:0] diff;
	logic [bba_pkg::ADDR_W-1:0] sh;
	logic [bba_pkg::CNT_W-1:0]  cnt;
	logic                       inr;

	always_comb begin
		sm1 = req.request_size - bba_pkg::SIZE_W'(1);
		hb = '0;
		for (int i = 0; i < bba_pkg::SIZE_W; i++) begin
			if (sm1[i]) hb = bba_pkg::LOG_W'(i + 1);
		end
		k = (req.request_size <= bba_pkg::SIZE_W'(1)) ? '0 : hb;
		if (k < cfg.min_block_log2) k = cfg.min_block_log2;
		top = bba_pkg::top_level(cfg);
		big = {1'b0, k} > ({1'b0, cfg.min_block_log2} + (bba_pkg::LOG_W+1)'(top));
		lv = bba_pkg::LVL_W'(k - cfg.min_block_log2);
		diff = req.free_address - cfg.base_address;
		sh = diff >> k;
		cnt = bba_pkg::pool_clamp(cfg) >> lv;
		inr = sh < bba_pkg::ADDR_W'(cnt);
	end

	always_comb begin
		cmd.lv = lv;
		cmd.idx = bba_pkg::IDX_W'(sh);
		cmd.k = k;
		priority if ((req.operation == bba_pkg::OP_ALLOC || req.operation == bba_pkg::OP_FREE)
				&& big) begin
			cmd.kind = bba_pkg::CMD_BIG;
		end else if (req.operation == bba_pkg::OP_ALLOC) begin
			cmd.kind = bba_pkg::CMD_ALLOC;
		end else if (req.operation == bba_pkg::OP_FREE) begin
			cmd.kind = inr ? bba_pkg::CMD_FREE : bba_pkg::CMD_NOP;
		end else if (req.operation == bba_pkg::OP_INIT) begin
			cmd.kind = bba_pkg::CMD_INIT;
		end else begin
			cmd.kind = bba_pkg::CMD_NOP;
		end
	end

	assign req.ready = !q_full && !sweep_busy;
	assign push = req.valid && req.ready;

endmodule

/* hw/rtl/bba_queue.sv */
// buddy block allocator: two-entry command queue between front and back
// depends on bba_pkg
module bba_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bba_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output bba_pkg::cmd_t dout
);

	bba_pkg::cmd_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign full = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign dout = slot_q[rd_q];

endmodule

/* hw/rtl/bba_back.sv */
// buddy block allocator back: bitmap memory, search, split, merge and clearing sequencer
// depends on bba_pkg and bba_if; holds the result register
module bba_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bba_pkg::cfg_t cfg,
	input  logic          q_valid,
	input  bba_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          sweep_busy,
	bba_rsp_if.source     rsp
);

	logic [bba_pkg::ROW_W-1:0] mem [bba_pkg::ROWS];

	bba_pkg::state_t           state_q, state_d;
	bba_pkg::phase_t           phase_q;
	bba_pkg::status_t          sts_q;
	logic [bba_pkg::LVL_W-1:0] lv_q, want_q;
	logic [bba_pkg::IDX_W-1:0] idx_q;
	logic [bba_pkg::RIL_W-1:0] ril_q;
	logic [bba_pkg::LOG_W-1:0] k_q;
	logic [bba_pkg::ROW_AW-1:0] sw_q;
	logic                      rst_sweep_q;
	logic                      addr_ok_q;
	logic [bba_pkg::ROW_W-1:0] rdata_q;
	logic                      out_valid_q;
	bba_pkg::status_t          out_status_q;
	logic [bba_pkg::ADDR_W-1:0] out_addr_q;

	logic [bba_pkg::LVL_W-1:0] top;
	logic [bba_pkg::CNT_W-1:0] pc;
	logic [bba_pkg::LVL_W-1:0] sw_lv;
	logic [bba_pkg::RIL_W-1:0] sw_ril;
	logic [bba_pkg::LVL_W-1:0] m_lv;
	logic [bba_pkg::RIL_W-1:0] m_ril;
	logic [bba_pkg::ROW_W-1:0] inval;
	logic [bba_pkg::ROW_AW-1:0] maddr;
	logic [bba_pkg::ROW_W-1:0] masked;
	logic [bba_pkg::ROW_W-1:0] free_vec;
	logic                      found;
	logic [bba_pkg::POS_W-1:0] fpos;
	logic [bba_pkg::POS_W-1:0] pos;
	logic                      buddy_busy;
	logic                      free_up;
	logic                      pair;
	logic                      wval;
	logic [bba_pkg::ROW_W-1:0] wm;
	logic [bba_pkg::ROW_W-1:0] wm_v;
	logic [bba_pkg::ROW_W-1:0] wdata;
	logic                      mem_we;
	logic                      last_row;
	logic                      sweep_last;
	logic                      out_free;

	always_comb begin
		top = bba_pkg::top_level(cfg);
		pc = bba_pkg::pool_clamp(cfg);
		sw_lv = bba_pkg::level_of_row(sw_q);
		sw_ril = bba_pkg::RIL_W'(sw_q - bba_pkg::row_addr(sw_lv, '0));
		pos = idx_q[bba_pkg::POS_W-1:0];
		m_lv = (state_q == bba_pkg::ST_SWEEP) ? sw_lv : lv_q;
		if (state_q == bba_pkg::ST_SWEEP) begin
			m_ril = sw_ril;
		end else if (state_q == bba_pkg::ST_SRCH_RD || state_q == bba_pkg::ST_SRCH_CHK) begin
			m_ril = ril_q;
		end else begin
			m_ril = bba_pkg::RIL_W'(idx_q >> bba_pkg::POS_W);
		end
		inval = bba_pkg::inval_mask(pc, m_lv, m_ril);
		maddr = bba_pkg::row_addr(m_lv, m_ril);
		masked = rdata_q | inval;
		free_vec = ~masked;
		found = |free_vec;
		fpos = '0;
		for (int i = bba_pkg::ROW_W - 1; i >= 0; i--) begin
			if (free_vec[i]) fpos = bba_pkg::POS_W'(i);
		end
		buddy_busy = masked[pos ^ bba_pkg::POS_W'(1)];
		free_up = (lv_q < top) && !buddy_busy;
		last_row = ril_q == bba_pkg::RIL_W'(bba_pkg::rows_of(int'(lv_q)) - 1);
		sweep_last = sw_q == bba_pkg::ROW_AW'(bba_pkg::ROWS - 1);
		out_free = !out_valid_q || rsp.ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::ST_SWEEP: begin
				if (sweep_last) state_d = rst_sweep_q ? bba_pkg::ST_IDLE : bba_pkg::ST_DONE;
			end
			bba_pkg::ST_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.kind)
						bba_pkg::CMD_ALLOC: state_d = bba_pkg::ST_SRCH_RD;
						bba_pkg::CMD_FREE:  state_d = bba_pkg::ST_RMW_RD;
						bba_pkg::CMD_INIT:  state_d = bba_pkg::ST_SWEEP;
						default:            state_d = bba_pkg::ST_DONE;
					endcase
				end
			end
			bba_pkg::ST_SRCH_RD: state_d = bba_pkg::ST_SRCH_CHK;
			bba_pkg::ST_SRCH_CHK: begin
				priority if (found) state_d = bba_pkg::ST_RMW_RD;
				else if (last_row && lv_q == top) state_d = bba_pkg::ST_DONE;
				else state_d = bba_pkg::ST_SRCH_RD;
			end
			bba_pkg::ST_RMW_RD: state_d = bba_pkg::ST_RMW_WR;
			bba_pkg::ST_RMW_WR: begin
				unique case (phase_q)
					bba_pkg::PH_FINAL: state_d = bba_pkg::ST_DONE;
					bba_pkg::PH_FREE:  state_d = free_up ? bba_pkg::ST_RMW_RD : bba_pkg::ST_DONE;
					default:           state_d = bba_pkg::ST_RMW_RD;
				endcase
			end
			bba_pkg::ST_DONE: begin
				if (out_free) state_d = bba_pkg::ST_IDLE;
			end
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	// outputs and write data
	always_comb begin
		q_pop = (state_q == bba_pkg::ST_IDLE) && q_valid;
		mem_we = (state_q == bba_pkg::ST_RMW_WR) || (state_q == bba_pkg::ST_SWEEP);
		pair = (phase_q == bba_pkg::PH_CLR) || (phase_q == bba_pkg::PH_FREE && free_up);
		wval = (phase_q == bba_pkg::PH_CLR) ? 1'b0
			: (phase_q == bba_pkg::PH_FREE) ? free_up : 1'b1;
		wm = bba_pkg::ROW_W'(1) << pos;
		if (pair) wm = wm | (bba_pkg::ROW_W'(1) << (pos ^ bba_pkg::POS_W'(1)));
		wm_v = wm & ~inval;
		if (state_q == bba_pkg::ST_SWEEP) begin
			wdata = (sw_lv == top) ? inval : '1;
		end else begin
			wdata = wval ? (rdata_q | wm_v) : (rdata_q & ~wm_v);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[maddr] <= wdata;
		rdata_q <= mem[maddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::ST_SWEEP;
			rst_sweep_q <= 1'b1;
			sw_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bba_pkg::ST_SWEEP) begin
				sw_q <= sweep_last ? '0 : sw_q + bba_pkg::ROW_AW'(1);
				if (sweep_last) rst_sweep_q <= 1'b0;
			end
			if (state_q == bba_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bba_pkg::ST_SWEEP: begin
				sts_q <= bba_pkg::STS_OK;
				addr_ok_q <= 1'b0;
			end
			bba_pkg::ST_IDLE: begin
				lv_q <= q_cmd.lv;
				want_q <= q_cmd.lv;
				idx_q <= q_cmd.idx;
				k_q <= q_cmd.k;
				ril_q <= '0;
				phase_q <= bba_pkg::PH_FREE;
				addr_ok_q <= 1'b0;
				sts_q <= (q_cmd.kind == bba_pkg::CMD_BIG) ? bba_pkg::STS_TOO_LARGE
					: bba_pkg::STS_OK;
			end
			bba_pkg::ST_SRCH_CHK: begin
				priority if (found) begin
					idx_q <= bba_pkg::IDX_W'({ril_q, fpos});
					phase_q <= (lv_q == want_q) ? bba_pkg::PH_FINAL : bba_pkg::PH_SET;
				end else if (!last_row) begin
					ril_q <= ril_q + bba_pkg::RIL_W'(1);
				end else if (lv_q != top) begin
					lv_q <= lv_q + bba_pkg::LVL_W'(1);
					ril_q <= '0;
				end else begin
					sts_q <= bba_pkg::STS_NO_FREE;
				end
			end
			bba_pkg::ST_RMW_WR: begin
				unique case (phase_q)
					bba_pkg::PH_SET: begin
						lv_q <= lv_q - bba_pkg::LVL_W'(1);
						idx_q <= idx_q << 1;
						phase_q <= bba_pkg::PH_CLR;
					end
					bba_pkg::PH_CLR: begin
						phase_q <= (lv_q == want_q) ? bba_pkg::PH_FINAL : bba_pkg::PH_SET;
					end
					bba_pkg::PH_FINAL: addr_ok_q <= 1'b1;
					bba_pkg::PH_FREE: begin
						if (free_up) begin
							lv_q <= lv_q + bba_pkg::LVL_W'(1);
							idx_q <= idx_q >> 1;
						end
					end
					default: addr_ok_q <= 1'b0;
				endcase
			end
			bba_pkg::ST_DONE: begin
				if (out_free) begin
					out_status_q <= sts_q;
					out_addr_q <= addr_ok_q
						? cfg.base_address + (bba_pkg::ADDR_W'(idx_q) << k_q) : '0;
				end
			end
			default: ;
		endcase
	end

	assign sweep_busy = rst_sweep_q;
	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.block_address = out_addr_q;

endmodule

/* hw/rtl/buddy_block_allocator_top.sv */
// Binary buddy allocator with one bitmap per block-size level, held as 32-bit
// rows in a single-port memory (67 rows). Every request is accepted in the
// front and then runs in the back: an allocate reads and checks bitmap rows
// until it finds a free block, then splits each level down to the wanted size
// (set the parent, then clear both children), makes a final write and returns
// its result; a free moves up a level, merging the pair, each time its buddy
// is also free; an oversized or ignored request goes straight to its result.
// Each allocate or free update is a read-modify-write of that memory port.
// Initialize rewrites all 67 rows; the same pass runs after reset, during which
// no request is taken. A two-entry queue sits between front and back and a
// result register at the output.
// depends on bba_pkg, bba_if, bba_front, bba_queue, bba_back
module buddy_block_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	bba_req_if.sink                       req,
	bba_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::ADDR_W-1:0]    cfg_data
);

	bba_pkg::cfg_t cfg_q;
	bba_pkg::cmd_t f_cmd;
	bba_pkg::cmd_t q_cmd;
	logic          push;
	logic          q_full;
	logic          q_valid;
	logic          q_pop;
	logic          sweep_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address <= '0;
			cfg_q.min_block_log2 <= bba_pkg::LOG_W'(12);
			cfg_q.max_block_log2 <= bba_pkg::LOG_W'(21);
			cfg_q.pool_min_blocks <= bba_pkg::POOL_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bba_pkg::REG_BASE: cfg_q.base_address <= cfg_data;
				bba_pkg::REG_MIN:  cfg_q.min_block_log2 <= cfg_data[bba_pkg::LOG_W-1:0];
				bba_pkg::REG_MAX:  cfg_q.max_block_log2 <= cfg_data[bba_pkg::LOG_W-1:0];
				bba_pkg::REG_POOL: cfg_q.pool_min_blocks <= cfg_data[bba_pkg::POOL_W-1:0];
				default: ;
			endcase
		end
	end

	bba_front u_front (
		.req        (req),
		.cfg        (cfg_q),
		.sweep_busy (sweep_busy),
		.q_full     (q_full),
		.push       (push),
		.cmd        (f_cmd)
	);

	bba_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_cmd)
	);

	bba_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.sweep_busy (sweep_busy),
		.rsp        (rsp)
	);

`ifndef SYNTHESIS
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_busy |-> !(req.valid && req.ready))
		else $error("request accepted during clearing pass");
	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != 2'(bba_pkg::STS_OK)) |-> rsp.block_address == '0)
		else $error("failed request returned an address");
	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command popped from empty queue");
`endif

endmodule
